// ----- src/framed_packet_crc_check_ack_defines.svh -----
// Assertion macros used by the frame check ack generator.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef FRAMED_PACKET_CRC_CHECK_ACK_DEFINES_SVH
`define FRAMED_PACKET_CRC_CHECK_ACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FPCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FPCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FPCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define FPCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/fpca_pkg.sv -----
// Package for the frame check and acknowledge block.
// Holds shared constants, codes, the ack descriptor type and the CRC-16 byte step.
package fpca_pkg;

    localparam int PAYLOAD_BYTES_DEF   = 5;
    localparam int MAX_FRAME_BYTES_DEF = 8;
    localparam int ACK_QUEUE_DEPTH     = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    typedef enum logic [7:0] {
        CFG_X_OFFSET = 8'd0,
        CFG_Y_OFFSET = 8'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ACK_SEQ    = 3'd0,
        ACK_X      = 3'd1,
        ACK_Y      = 3'd2,
        ACK_STATUS = 3'd3,
        ACK_CRC_LO = 3'd4,
        ACK_CRC_HI = 3'd5
    } t_ack_pos;

    typedef struct packed {
        logic [7:0] seq;
        logic [7:0] x;
        logic [7:0] y;
        logic       ok;
    } t_ack_desc;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/fpca_if.sv -----
// Handshake interfaces for the received byte, ack byte and configuration channels.
// Depends on nothing.
interface fpca_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source(output valid, rx_byte, frame_end, input ready);
    modport sink(input valid, rx_byte, frame_end, output ready);
endinterface

interface fpca_ack_if;
    logic       valid;
    logic       ready;
    logic [7:0] ack_byte;
    logic       ack_last;
    logic       packet_ok;

    modport source(output valid, ack_byte, ack_last, packet_ok, input ready);
    modport sink(input valid, ack_byte, ack_last, packet_ok, output ready);
endinterface

interface fpca_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- src/framed_packet_crc_check_ack.sv -----
// Top level of the frame check and acknowledge block.
// Depends on fpca_pkg, fpca_if, fpca_front, fpca_queue and fpca_back.
//
// Received frame bytes arrive one beat at a time on i_rx, with frame_end set on
// the last byte of a frame. A five-byte raw frame and an eight-byte checked frame
// (sequence, payload, CRC low, CRC high) each produce a six-byte ack on o_ack:
// sequence, X byte, Y byte, status, then the ack's own CRC-16, low byte first.
// Frames of any other length produce nothing. i_cfg writes the X and Y payload
// offsets; index 0 is the X offset, index 1 the Y offset, other indexes are ignored.
// The input takes one byte per cycle; the running CRC update fits in that cycle.
// The first ack beat is valid once its descriptor has passed the queue into the ack
// generator; the six ack beats follow one per cycle while o_ack.ready stays high.
// Up to two finished acks wait in a queue; the input stalls only while that queue
// is full, so a stalled receiver holds the ack bytes and eventually the input.
// Reset clears the byte count, sets the CRC to its initial value and the offsets
// to 0 and 1, and empties the queue; there is no clearing pass.
module framed_packet_crc_check_ack #(
    parameter int PAYLOAD_BYTES   = fpca_pkg::PAYLOAD_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = fpca_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpca_rx_if.sink     i_rx,
    fpca_cfg_if.sink    i_cfg,
    fpca_ack_if.source  o_ack
);

    logic                w_push, w_full, w_q_valid, w_pop;
    fpca_pkg::t_ack_desc w_push_desc, w_q_desc;

    fpca_front #(
        .PAYLOAD_BYTES  (PAYLOAD_BYTES),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .rx     (i_rx),
        .cfg    (i_cfg),
        .i_full (w_full),
        .o_push (w_push),
        .o_desc (w_push_desc)
    );

    fpca_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_desc),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_data (w_q_desc),
        .i_pop  (w_pop)
    );

    fpca_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .i_desc (w_q_desc),
        .o_pop  (w_pop),
        .ack    (o_ack)
    );

endmodule

// ----- src/fpca_front.sv -----
// Front end: takes frame bytes, keeps the running CRC, captures the bytes an ack needs
// and classifies each frame at its end. Depends on fpca_pkg and fpca_if.
module fpca_front #(
    parameter int PAYLOAD_BYTES   = fpca_pkg::PAYLOAD_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = fpca_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fpca_rx_if.sink             rx,
    fpca_cfg_if.sink            cfg,
    input  logic                i_full,
    output logic                o_push,
    output fpca_pkg::t_ack_desc o_desc
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + PAYLOAD_BYTES + 4);
    localparam logic [CW-1:0] C_ZERO    = CW'(0);
    localparam logic [CW-1:0] C_ONE     = CW'(1);
    localparam logic [CW-1:0] C_PAY     = CW'(PAYLOAD_BYTES);
    localparam logic [CW-1:0] C_MAX     = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] C_CRC_END = CW'(PAYLOAD_BYTES + 1);
    localparam logic [CW-1:0] C_RX_LO   = CW'(PAYLOAD_BYTES + 1);
    localparam logic [CW-1:0] C_RX_HI   = CW'(PAYLOAD_BYTES + 2);
    localparam logic [CW-1:0] C_CHK_LEN = CW'(PAYLOAD_BYTES + 3);

    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [2:0]    r_xoff;
    logic [2:0]    r_yoff;
    logic [7:0]    r_seq, r_x_raw, r_x_chk, r_y_raw, r_y_chk, r_rx_lo, r_rx_hi;

    logic [7:0]    n_seq, n_x_raw, n_x_chk, n_y_raw, n_y_chk, n_rx_lo, n_rx_hi;
    logic [15:0]   n_crc;
    logic [CW-1:0] n_len;
    logic [CW-1:0] w_x_raw_idx, w_x_chk_idx, w_y_raw_idx, w_y_chk_idx;
    logic          w_acc, w_raw, w_chk, w_crc_ok;
    logic [7:0]    w_b;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !i_full;
    assign w_acc     = rx.valid && rx.ready;
    assign w_b       = rx.rx_byte;

    always_comb begin
        w_x_raw_idx = (CW'(r_xoff) >= C_PAY) ? (C_PAY - C_ONE) : CW'(r_xoff);
        w_y_raw_idx = (CW'(r_yoff) >= C_PAY) ? (C_PAY - C_ONE) : CW'(r_yoff);
        w_x_chk_idx = w_x_raw_idx + C_ONE;
        w_y_chk_idx = w_y_raw_idx + C_ONE;

        n_seq   = (r_count == C_ZERO)      ? w_b : r_seq;
        n_x_raw = (r_count == w_x_raw_idx) ? w_b : r_x_raw;
        n_x_chk = (r_count == w_x_chk_idx) ? w_b : r_x_chk;
        n_y_raw = (r_count == w_y_raw_idx) ? w_b : r_y_raw;
        n_y_chk = (r_count == w_y_chk_idx) ? w_b : r_y_chk;
        n_rx_lo = (r_count == C_RX_LO)     ? w_b : r_rx_lo;
        n_rx_hi = (r_count == C_RX_HI)     ? w_b : r_rx_hi;
        n_crc   = (r_count < C_CRC_END) ? fpca_pkg::crc16_byte(r_crc, w_b) : r_crc;
        n_len   = (r_count <= C_MAX) ? (r_count + C_ONE) : r_count;

        w_raw    = (n_len == C_PAY) && (n_len <= C_MAX);
        w_chk    = (n_len == C_CHK_LEN) && (n_len <= C_MAX);
        w_crc_ok = ({n_rx_hi, n_rx_lo} == n_crc);

        o_push = w_acc && rx.frame_end && (w_raw || w_chk);
        if (w_chk) begin
            o_desc.seq = n_seq;
            o_desc.x   = (w_x_chk_idx >= C_MAX) ? 8'h00 : n_x_chk;
            o_desc.y   = (w_y_chk_idx >= C_MAX) ? 8'h00 : n_y_chk;
            o_desc.ok  = w_crc_ok;
        end else begin
            o_desc.seq = 8'h00;
            o_desc.x   = (w_x_raw_idx >= C_MAX) ? 8'h00 : n_x_raw;
            o_desc.y   = (w_y_raw_idx >= C_MAX) ? 8'h00 : n_y_raw;
            o_desc.ok  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= C_ZERO;
            r_crc   <= fpca_pkg::CRC_INIT;
            r_xoff  <= 3'd0;
            r_yoff  <= 3'd1;
        end else begin
            if (cfg.valid) begin
                case (cfg.index)
                    fpca_pkg::CFG_X_OFFSET: r_xoff <= cfg.data[2:0];
                    fpca_pkg::CFG_Y_OFFSET: r_yoff <= cfg.data[2:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                if (rx.frame_end) begin
                    r_count <= C_ZERO;
                    r_crc   <= fpca_pkg::CRC_INIT;
                end else begin
                    r_count <= n_len;
                    r_crc   <= n_crc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_seq   <= n_seq;
            r_x_raw <= n_x_raw;
            r_x_chk <= n_x_chk;
            r_y_raw <= n_y_raw;
            r_y_chk <= n_y_chk;
            r_rx_lo <= n_rx_lo;
            r_rx_hi <= n_rx_hi;
        end
    end

endmodule

// ----- src/fpca_queue.sv -----
// Short queue of ack descriptors between the front end and the ack generator.
// Depends on fpca_pkg.
module fpca_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fpca_pkg::t_ack_desc i_data,
    output logic                o_full,
    output logic                o_valid,
    output fpca_pkg::t_ack_desc o_data,
    input  logic                i_pop
);

    localparam int DEPTH = fpca_pkg::ACK_QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    fpca_pkg::t_ack_desc r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != NW'(0));
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/fpca_back.sv -----
// Ack generator: sends the six ack bytes of one descriptor, computing the ack CRC
// one byte per beat. Depends on fpca_pkg, fpca_if and the assertion macro header.
`include "framed_packet_crc_check_ack_defines.svh"

module fpca_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fpca_pkg::t_ack_desc i_desc,
    output logic                o_pop,
    fpca_ack_if.source          ack
);

    logic                r_busy;
    fpca_pkg::t_ack_desc r_desc;
    fpca_pkg::t_ack_pos  r_idx;
    logic [15:0]         r_crc;

    logic       w_acc, w_last;
    logic [7:0] w_byte;

    always_comb begin
        case (r_idx)
            fpca_pkg::ACK_SEQ:    w_byte = r_desc.seq;
            fpca_pkg::ACK_X:      w_byte = r_desc.x;
            fpca_pkg::ACK_Y:      w_byte = r_desc.y;
            fpca_pkg::ACK_STATUS: w_byte = {7'd0, !r_desc.ok};
            fpca_pkg::ACK_CRC_LO: w_byte = r_crc[7:0];
            fpca_pkg::ACK_CRC_HI: w_byte = r_crc[15:8];
            default:              w_byte = 8'h00;
        endcase
    end

    assign w_last        = (r_idx == fpca_pkg::ACK_CRC_HI);
    assign w_acc         = ack.valid && ack.ready;
    assign o_pop         = i_valid && (!r_busy || (w_acc && w_last));
    assign ack.valid     = r_busy;
    assign ack.ack_byte  = w_byte;
    assign ack.ack_last  = w_last;
    assign ack.packet_ok = r_desc.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= fpca_pkg::ACK_SEQ;
            r_crc  <= fpca_pkg::CRC_INIT;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= fpca_pkg::ACK_SEQ;
            r_crc  <= fpca_pkg::CRC_INIT;
        end else if (w_acc) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= fpca_pkg::t_ack_pos'(r_idx + 3'd1);
            end
            if (r_idx <= fpca_pkg::ACK_STATUS) begin
                r_crc <= fpca_pkg::crc16_byte(r_crc, w_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
    end

    `FPCA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_busy && !ack.ready, r_busy && $stable(r_idx) && $stable(r_crc), "Stalled ack beat moved.")
    `FPCA_ASSERT_NEXT(a_idle_after_ack, i_clk, i_rst_n, w_acc && w_last && !i_valid, !r_busy, "Ack generator stayed busy with no work.")
    `FPCA_ASSERT_NEXT(a_start_clean, i_clk, i_rst_n, o_pop, r_busy && (r_idx == fpca_pkg::ACK_SEQ) && (r_crc == fpca_pkg::CRC_INIT), "Ack did not start at its first byte.")

endmodule
